/* rtl/bsc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and functions of the barometric compensation core
// Payload structs, calibration fields, queue entry, divider stage and the
// helpers for 64-bit wrapping multiplies built from 32x32 partial products.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam logic [1:0] CFG_TEMP_CALIB  = 2'd0;
  localparam logic [1:0] CFG_PRESS_LOW   = 2'd1;
  localparam logic [1:0] CFG_PRESS_HIGH  = 2'd2;
  localparam logic [1:0] CFG_PRESS_P9    = 2'd3;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic [15:0] temperature_centi;
    logic [31:0] pressure_q24_8;
    logic        zero_divisor;
  } out_t;

  // All words are raw bit patterns; t1 and p1 are unsigned, the rest signed.
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } calib_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic [15:0] temp;
    logic        zero;
    logic        qneg;
    logic [63:0] nmag;
    logic [30:0] dmag;
  } qent_t;

  // One step of the restoring divider. nq holds the numerator bits still to
  // be consumed at the top and the quotient bits collected at the bottom.
  typedef struct packed {
    logic [15:0] temp;
    logic        zero;
    logic        qneg;
    logic [30:0] rem;
    logic [63:0] nq;
    logic [30:0] dmag;
  } div_t;

  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
  } part_t;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Partial products of the low 64 bits of x*y.
  function automatic part_t mul_part(input logic [63:0] x, input logic [63:0] y);
    part_t r;
    r.ll = {32'b0, x[31:0]} * {32'b0, y[31:0]};
    r.lh = x[31:0] * y[63:32];
    r.hl = x[63:32] * y[31:0];
    return r;
  endfunction

  function automatic logic [63:0] mul_join(input part_t p);
    return p.ll + {p.lh + p.hl, 32'b0};
  endfunction

  function automatic div_t div_step(input div_t s);
    div_t        r;
    logic [30:0] trial;
    r     = s;
    trial = {s.rem[29:0], s.nq[63]};
    if (trial >= s.dmag) begin
      r.rem = trial - s.dmag;
      r.nq  = {s.nq[62:0], 1'b1};
    end else begin
      r.rem = trial;
      r.nq  = {s.nq[62:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/bsc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_front: temperature and pressure-divisor pipeline
// Computes fine temperature, the saturated temperature, the pressure
// numerator and divisor, and classifies the item for the divider.
// ----------------------------------------------------------------------------
module bsc_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire bsc_pkg::in_t   in_data,
  input  wire bsc_pkg::calib_t cal,
  input  wire logic           q_ready,
  output logic                q_push,
  output bsc_pkg::qent_t      q_data
);

  logic [13:0] vld_r;
  logic        en;

  logic [19:0] rt0_r;
  logic [19:0] rp_r [0:9];
  logic [15:0] tmp_r [5:12];

  logic signed [18:0] x1_r, x1_nxt;
  logic signed [17:0] d_r, d_nxt;
  logic signed [34:0] m1_r, m1_nxt, m1_sh;
  logic signed [35:0] dd_r, dd_nxt, dd_sh;
  logic signed [23:0] at_r, at_nxt, ddt;
  logic signed [39:0] m2_r, m2_nxt, m2_sh;
  logic signed [25:0] bt;
  logic signed [31:0] tf_r, tf_nxt;
  logic signed [35:0] t5, t8;
  logic        [15:0] temp_nxt;
  logic signed [31:0] va_r, va_nxt;
  logic [63:0] aa_r, aa_nxt, ap5_r, ap5_nxt, ap2_r, ap2_nxt;
  bsc_pkg::part_t pt6_r, pt3_r, ptv_r, ptn_r;
  logic [63:0] ap5b_r, ap2b_r, ap5c_r, ap2c_r;
  logic [63:0] b1_r, a3_r, a3s;
  logic [63:0] bb_r, bb_nxt, v_r, v_nxt;
  logic [20:0] p21;
  logic [63:0] num0_r, num0_nxt, v1, v1s, num_r;
  logic [30:0] var1_r, var1b_r;
  bsc_pkg::qent_t q_r, q_nxt;

  assign en       = !vld_r[13] || q_ready;
  assign in_ready = en;
  assign q_push   = vld_r[13] && q_ready;
  assign q_data   = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[12:0], in_valid};
    end
  end

  assign x1_nxt = $signed({2'b00, rt0_r[19:3]}) - $signed({2'b00, cal.t1, 1'b0});
  assign d_nxt  = $signed({2'b00, rt0_r[19:4]}) - $signed({2'b00, cal.t1});
  assign m1_nxt = x1_r * $signed(cal.t2);
  assign dd_nxt = d_r * d_r;
  assign dd_sh  = dd_r >>> 12;
  assign ddt    = $signed(dd_sh[23:0]);
  assign m2_nxt = ddt * $signed(cal.t3);
  assign m1_sh  = m1_r >>> 11;
  assign at_nxt = $signed(m1_sh[23:0]);
  assign m2_sh  = m2_r >>> 14;
  assign bt     = $signed(m2_sh[25:0]);
  assign tf_nxt = at_r + bt;
  assign t5     = tf_r * 36'sd5 + 36'sd128;
  assign t8     = t5 >>> 8;

  always_comb begin
    if (t8 > 36'sd32767) begin
      temp_nxt = 16'h7FFF;
    end else if (t8 < -36'sd32768) begin
      temp_nxt = 16'h8000;
    end else begin
      temp_nxt = t8[15:0];
    end
  end

  assign va_nxt  = tf_r - 32'sd128000;
  assign aa_nxt  = va_r * va_r;
  assign ap5_nxt = va_r * $signed(cal.p5);
  assign ap2_nxt = va_r * $signed(cal.p2);

  // Second-order terms wrap modulo 2^64 like the reference formulas.
  assign a3s    = $signed(a3_r) >>> 8;
  assign bb_nxt = b1_r + (ap5c_r << 17) + (bsc_pkg::sx16(cal.p4) << 35);
  assign v_nxt  = 64'h0000_8000_0000_0000 + a3s + (ap2c_r << 12);

  assign p21      = 21'd1048576 - {1'b0, rp_r[9]};
  assign num0_nxt = {12'b0, p21, 31'b0} - bb_r;
  assign v1       = bsc_pkg::mul_join(ptv_r);
  assign v1s      = $signed(v1) >>> 33;

  always_comb begin
    q_nxt.temp = tmp_r[12];
    q_nxt.zero = (var1b_r == '0);
    q_nxt.qneg = num_r[63] ^ var1b_r[30];
    q_nxt.nmag = num_r[63] ? (~num_r + 64'd1) : num_r;
    q_nxt.dmag = var1b_r[30] ? (~var1b_r + 31'd1) : var1b_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt0_r   <= in_data.raw_temperature;
      rp_r[0] <= in_data.raw_pressure;
      for (int i = 1; i < 10; i++) begin
        rp_r[i] <= rp_r[i-1];
      end
      x1_r <= x1_nxt;
      d_r  <= d_nxt;
      m1_r <= m1_nxt;
      dd_r <= dd_nxt;
      at_r <= at_nxt;
      m2_r <= m2_nxt;
      tf_r <= tf_nxt;
      tmp_r[5] <= temp_nxt;
      for (int i = 6; i < 13; i++) begin
        tmp_r[i] <= tmp_r[i-1];
      end
      va_r    <= va_nxt;
      aa_r    <= aa_nxt;
      ap5_r   <= ap5_nxt;
      ap2_r   <= ap2_nxt;
      pt6_r   <= bsc_pkg::mul_part(aa_r, bsc_pkg::sx16(cal.p6));
      pt3_r   <= bsc_pkg::mul_part(aa_r, bsc_pkg::sx16(cal.p3));
      ap5b_r  <= ap5_r;
      ap2b_r  <= ap2_r;
      b1_r    <= bsc_pkg::mul_join(pt6_r);
      a3_r    <= bsc_pkg::mul_join(pt3_r);
      ap5c_r  <= ap5b_r;
      ap2c_r  <= ap2b_r;
      bb_r    <= bb_nxt;
      v_r     <= v_nxt;
      ptv_r   <= bsc_pkg::mul_part(v_r, {48'b0, cal.p1});
      num0_r  <= num0_nxt;
      var1_r  <= v1s[30:0];
      ptn_r   <= bsc_pkg::mul_part(num0_r, 64'd3125);
      num_r   <= bsc_pkg::mul_join(ptn_r);
      var1b_r <= var1_r;
      q_r     <= q_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/bsc_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_queue: small FIFO between the front and the back
// Lets the front keep taking items while the back is stalled by the receiver.
// ----------------------------------------------------------------------------
module bsc_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire bsc_pkg::qent_t wdata,
  output logic                not_full,
  input  wire logic           pop,
  output logic                not_empty,
  output bsc_pkg::qent_t      rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bsc_pkg::qent_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign not_full  = (cnt_r != CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/bsc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_back: pressure divider and final correction pipeline
// A 64-stage restoring divider followed by the P7..P9 correction terms and
// the output register.
// ----------------------------------------------------------------------------
module bsc_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire bsc_pkg::qent_t  q_data,
  input  wire bsc_pkg::calib_t cal,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output bsc_pkg::out_t        out_data
);

  localparam int NDIV = 64;

  logic           en;
  logic [NDIV-1:0] dvld_r;
  bsc_pkg::div_t  dstg_r [NDIV];
  bsc_pkg::div_t  din [NDIV];
  logic [6:0]     pv_r;

  logic [15:0] tmp_r [0:5];
  logic        zr_r  [0:5];

  logic [63:0] p0_r, p0_nxt, s_nxt, p1_r, s1_r, p2_r, s2_r, t9_r, b8_r;
  logic [63:0] p3_r, b8b_r, p4_r, b8c_r, a9_r, a9s, b8s, sum_r, sum8, fin;
  bsc_pkg::part_t pt9_r, pt8_r, pta_r;
  bsc_pkg::out_t  out_r, out_nxt;

  assign en        = !pv_r[6] || out_ready;
  assign q_pop     = en && q_valid;
  assign out_valid = pv_r[6];
  assign out_data  = out_r;

  always_comb begin
    din[0].temp = q_data.temp;
    din[0].zero = q_data.zero;
    din[0].qneg = q_data.qneg;
    din[0].rem  = '0;
    din[0].nq   = q_data.nmag;
    din[0].dmag = q_data.dmag;
    for (int i = 1; i < NDIV; i++) begin
      din[i] = dstg_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r <= '0;
      pv_r   <= '0;
    end else if (en) begin
      dvld_r <= {dvld_r[NDIV-2:0], q_valid};
      pv_r   <= {pv_r[5:0], dvld_r[NDIV-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NDIV; i++) begin
        dstg_r[i] <= bsc_pkg::div_step(din[i]);
      end
    end
  end

  assign p0_nxt = dstg_r[NDIV-1].qneg ? (~dstg_r[NDIV-1].nq + 64'd1) : dstg_r[NDIV-1].nq;
  assign s_nxt  = $signed(p0_r) >>> 13;
  assign a9s    = $signed(a9_r) >>> 25;
  assign b8s    = $signed(b8c_r) >>> 19;
  assign sum8   = $signed(sum_r) >>> 8;
  assign fin    = sum8 + (bsc_pkg::sx16(cal.p7) << 4);

  always_comb begin
    out_nxt.temperature_centi = tmp_r[5];
    out_nxt.zero_divisor      = zr_r[5];
    if (zr_r[5] || fin[63]) begin
      out_nxt.pressure_q24_8 = '0;
    end else if (fin[63:32] != '0) begin
      out_nxt.pressure_q24_8 = '1;
    end else begin
      out_nxt.pressure_q24_8 = fin[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tmp_r[0] <= dstg_r[NDIV-1].temp;
      zr_r[0]  <= dstg_r[NDIV-1].zero;
      for (int i = 1; i < 6; i++) begin
        tmp_r[i] <= tmp_r[i-1];
        zr_r[i]  <= zr_r[i-1];
      end
      p0_r  <= p0_nxt;
      p1_r  <= p0_r;
      s1_r  <= s_nxt;
      pt9_r <= bsc_pkg::mul_part(s_nxt, bsc_pkg::sx16(cal.p9));
      pt8_r <= bsc_pkg::mul_part(p0_r, bsc_pkg::sx16(cal.p8));
      p2_r  <= p1_r;
      s2_r  <= s1_r;
      t9_r  <= bsc_pkg::mul_join(pt9_r);
      b8_r  <= bsc_pkg::mul_join(pt8_r);
      p3_r  <= p2_r;
      b8b_r <= b8_r;
      pta_r <= bsc_pkg::mul_part(t9_r, s2_r);
      p4_r  <= p3_r;
      b8c_r <= b8b_r;
      a9_r  <= bsc_pkg::mul_join(pta_r);
      sum_r <= p4_r + a9s + b8s;
      out_r <= out_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/barometric_sensor_compensation_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_core: integer pressure/temperature compensation
// Turns raw temperature and pressure readings into 0.01 degC and Q24.8 Pa.
// ----------------------------------------------------------------------------
// Usage:
//   Write the four calibration registers through the cfg_ channel while the
//   core is idle; cfg_ready is always high. Index 0 is the T1..T3 word, 1 and 2
//   the P1..P8 words, 3 is P9. All registers clear to zero at reset.
//   Present raw readings on the in_ channel; one transfer is one sample pair.
//   Each sample yields exactly one out_ transfer, in order.
//   Throughput: one sample per cycle while out_ready is high. An input transfer
//   reaches out_valid through the 14-stage front pipeline, the queue, the
//   64-stage one-bit-per-stage divider and 7 correction stages.
//   When the receiver holds out_ready low the back pipeline freezes and the
//   queue between front and back absorbs items; the front keeps accepting
//   until the queue fills, then in_ready drops.
//   Reset (rst_n low, synchronous) empties the pipelines and the queue.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bsc_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bsc_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [63:0]   cfg_data
);

  logic [47:0] temp_calib_r;
  logic [63:0] press_low_r;
  logic [63:0] press_high_r;
  logic [15:0] press_p9_r;

  bsc_pkg::calib_t cal;
  bsc_pkg::qent_t  fq_data, qb_data;
  logic            q_push, q_not_full, q_pop, q_not_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r <= '0;
      press_low_r  <= '0;
      press_high_r <= '0;
      press_p9_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bsc_pkg::CFG_TEMP_CALIB: temp_calib_r <= cfg_data[47:0];
        bsc_pkg::CFG_PRESS_LOW:  press_low_r  <= cfg_data;
        bsc_pkg::CFG_PRESS_HIGH: press_high_r <= cfg_data;
        bsc_pkg::CFG_PRESS_P9:   press_p9_r   <= cfg_data[15:0];
        default:                 press_p9_r   <= press_p9_r;
      endcase
    end
  end

  always_comb begin
    cal.t1 = temp_calib_r[15:0];
    cal.t2 = temp_calib_r[31:16];
    cal.t3 = temp_calib_r[47:32];
    cal.p1 = press_low_r[15:0];
    cal.p2 = press_low_r[31:16];
    cal.p3 = press_low_r[47:32];
    cal.p4 = press_low_r[63:48];
    cal.p5 = press_high_r[15:0];
    cal.p6 = press_high_r[31:16];
    cal.p7 = press_high_r[47:32];
    cal.p8 = press_high_r[63:48];
    cal.p9 = press_p9_r;
  end

  bsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cal      (cal),
    .q_ready  (q_not_full),
    .q_push   (q_push),
    .q_data   (fq_data)
  );

  bsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (fq_data),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (qb_data)
  );

  bsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_pop     (q_pop),
    .q_data    (qb_data),
    .cal       (cal),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
